>>> rtl/hcbp_pkg.sv
// Shared types, constants and helpers for the Huffman code bit packer.
`timescale 1ns / 1ps
package hcbp_pkg;

   localparam int SYMBOLS      = 256;
   localparam int MAX_CODE_LEN = 31;

   localparam int WORD_W  = 32;
   localparam int SYM_W   = 8;
   localparam int BYTE_W  = 8;
   localparam int CNT_W   = 3;
   localparam int TBL_AW  = (SYMBOLS > 1) ? $clog2(SYMBOLS) : 1;
   localparam int IDX_W   = $clog2(WORD_W);
   localparam int REM_W   = $clog2(WORD_W * 2);
   localparam int STEP_W  = CNT_W + 1;

   typedef enum logic [1:0] {
      CMD_LOAD   = 2'd0,
      CMD_ENCODE = 2'd1,
      CMD_FLUSH  = 2'd2,
      CMD_NONE   = 2'd3
   } cmd_type;

   typedef struct packed {
      logic [1:0]        command;
      logic [SYM_W-1:0]  symbol;
      logic [WORD_W-1:0] code_word;
   } req_type;

   typedef struct packed {
      logic [BYTE_W-1:0] out_byte;
      logic              last;
   } rsp_type;

   // table access from the sequencer
   typedef struct packed {
      logic              wr_en;
      logic              rd_en;
      logic [TBL_AW-1:0] addr;
      logic [WORD_W-1:0] wr_data;
   } tbl_req_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_LOOKUP,
      ST_EMIT,
      ST_FLUSH_DATA,
      ST_FLUSH_CNT
   } state_type;

   // index of the highest set bit; zero for a zero word
   function automatic logic [IDX_W-1:0] msb_index(input logic [WORD_W-1:0] w);
      logic [IDX_W-1:0] idx;
      idx = '0;
      for (int i = 0; i < WORD_W; i++) begin
         if (w[i]) begin
            idx = IDX_W'(i);
         end
      end
      return idx;
   endfunction

   function automatic logic [BYTE_W-1:0] bit_reverse(input logic [BYTE_W-1:0] b);
      logic [BYTE_W-1:0] r;
      for (int i = 0; i < BYTE_W; i++) begin
         r[i] = b[BYTE_W-1-i];
      end
      return r;
   endfunction

endpackage

>>> rtl/huffman_code_bit_packer.sv
// Huffman code bit packer top level: command sequencer, bit buffer and output register.
// Load: table write, no response. Encode: table read in the accept cycle, a length step,
//   then one step per chunk of code bits that fills or ends the pending byte (up to 5 for
//   a 31-bit code); a full byte waits while the output is stalled. Bytes are registered.
// Flush: one or two bytes, each sent when the output is free. Next request taken in idle.
// Synchronous reset clears the state, table valid bits, bit buffer and response valid.
`timescale 1ns / 1ps
module huffman_code_bit_packer (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_stall,
   input  hcbp_pkg::req_type req_data,
   output logic              rsp_valid,
   input  logic              rsp_stall,
   output hcbp_pkg::rsp_type rsp_data
);
   import hcbp_pkg::*;

   state_type         state_ff, state_in;
   logic [BYTE_W-1:0] buf_ff, buf_in;
   logic [CNT_W-1:0]  cnt_ff, cnt_in;
   logic [WORD_W-1:0] code_ff, code_in;
   logic [REM_W-1:0]  rem_ff, rem_in;
   logic              inrange_ff, inrange_in;
   logic              rsp_valid_ff, rsp_valid_in;
   rsp_type           rsp_data_ff, rsp_data_in;

   tbl_req_type       tbl_req;
   logic [WORD_W-1:0] tbl_rd_data;

   logic              accept;
   logic              in_range;
   logic              out_free;
   logic [WORD_W-1:0] word;
   logic [REM_W-1:0]  len;
   logic [STEP_W-1:0] space;
   logic [STEP_W-1:0] take;
   logic [STEP_W-1:0] fill;
   logic [BYTE_W-1:0] ins;
   logic [REM_W-1:0]  rem_left;
   logic              full;
   logic              step;
   logic              emit;
   rsp_type           emit_data;

   hcbp_table u_table (
      .clock   (clock),
      .reset   (reset),
      .tbl_req (tbl_req),
      .rd_data (tbl_rd_data)
   );

   assign accept   = req_valid && !req_stall;
   assign in_range = {1'b0, req_data.symbol} < (SYM_W + 1)'(SYMBOLS);
   assign out_free = !rsp_valid_ff || !rsp_stall;

   assign tbl_req.wr_en   = accept && (req_data.command == CMD_LOAD) && in_range;
   assign tbl_req.rd_en   = accept && (req_data.command == CMD_ENCODE) && in_range;
   assign tbl_req.addr    = req_data.symbol[TBL_AW-1:0];
   assign tbl_req.wr_data = req_data.code_word;

   // code length after the table read, clamped
   always_comb begin
      word = inrange_ff ? tbl_rd_data : '0;
      len  = REM_W'(msb_index(word));
      if (len > REM_W'(MAX_CODE_LEN)) begin
         len = REM_W'(MAX_CODE_LEN);
      end
   end

   // bits that go into the pending byte this cycle
   always_comb begin
      space    = STEP_W'(BYTE_W) - STEP_W'(cnt_ff);
      take     = (rem_ff < REM_W'(space)) ? STEP_W'(rem_ff) : space;
      fill     = STEP_W'(cnt_ff) + take;
      full     = fill[CNT_W];
      ins      = (bit_reverse(code_ff[BYTE_W-1:0]) & ~(8'hFF >> take)) >> cnt_ff;
      rem_left = rem_ff - REM_W'(take);
   end

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (accept && req_data.command == CMD_ENCODE) begin
               state_in = ST_LOOKUP;
            end else if (accept && req_data.command == CMD_FLUSH) begin
               state_in = (cnt_ff != '0) ? ST_FLUSH_DATA : ST_FLUSH_CNT;
            end
         end
         ST_LOOKUP: begin
            if (word == '0 || len != '0) begin
               state_in = ST_EMIT;
            end else begin
               state_in = ST_IDLE;
            end
         end
         ST_EMIT: begin
            if (step && rem_left == '0) begin
               state_in = ST_IDLE;
            end
         end
         ST_FLUSH_DATA: begin
            if (out_free) begin
               state_in = ST_FLUSH_CNT;
            end
         end
         ST_FLUSH_CNT: begin
            if (out_free) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // datapath and outputs
   always_comb begin
      buf_in     = buf_ff;
      cnt_in     = cnt_ff;
      code_in    = code_ff;
      rem_in     = rem_ff;
      inrange_in = inrange_ff;
      step       = 1'b0;
      emit       = 1'b0;
      emit_data  = '0;
      req_stall  = (state_ff != ST_IDLE);

      unique case (state_ff)
         ST_IDLE: begin
            if (accept && req_data.command == CMD_ENCODE) begin
               inrange_in = in_range;
            end
         end
         ST_LOOKUP: begin
            if (word == '0) begin
               // unloaded entry sends a single zero bit
               code_in = '0;
               rem_in  = REM_W'(1);
            end else begin
               code_in = word;
               rem_in  = len;
            end
         end
         ST_EMIT: begin
            step = !full || out_free;
            if (step) begin
               code_in = code_ff >> take;
               rem_in  = rem_left;
               if (full) begin
                  emit               = 1'b1;
                  emit_data.out_byte = buf_ff | ins;
                  emit_data.last     = (rem_left < REM_W'(BYTE_W));
                  buf_in             = '0;
                  cnt_in             = '0;
               end else begin
                  buf_in = buf_ff | ins;
                  cnt_in = fill[CNT_W-1:0];
               end
            end
         end
         ST_FLUSH_DATA: begin
            if (out_free) begin
               emit               = 1'b1;
               emit_data.out_byte = buf_ff;
               emit_data.last     = 1'b0;
            end
         end
         ST_FLUSH_CNT: begin
            if (out_free) begin
               emit               = 1'b1;
               emit_data.out_byte = BYTE_W'(cnt_ff);
               emit_data.last     = 1'b1;
               buf_in             = '0;
               cnt_in             = '0;
            end
         end
         default: begin
            req_stall = 1'b1;
         end
      endcase
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_data_in  = rsp_data_ff;
      if (emit) begin
         rsp_valid_in = 1'b1;
         rsp_data_in  = emit_data;
      end else if (!rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         buf_ff       <= '0;
         cnt_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         buf_ff       <= buf_in;
         cnt_ff       <= cnt_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      code_ff     <= code_in;
      rem_ff      <= rem_in;
      inrange_ff  <= inrange_in;
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

endmodule

>>> rtl/hcbp_table.sv
// Code table memory with per-entry valid bits cleared at reset.
`timescale 1ns / 1ps
module hcbp_table (
   input  logic                        clock,
   input  logic                        reset,
   input  hcbp_pkg::tbl_req_type       tbl_req,
   output logic [hcbp_pkg::WORD_W-1:0] rd_data
);
   import hcbp_pkg::*;

   logic [WORD_W-1:0] mem [SYMBOLS];
   logic [SYMBOLS-1:0] valid_ff;
   logic [SYMBOLS-1:0] valid_in;
   logic [WORD_W-1:0] rd_data_ff;
   logic              rd_hit_ff;

   always_comb begin
      valid_in = valid_ff;
      if (tbl_req.wr_en) begin
         valid_in[tbl_req.addr] = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (tbl_req.wr_en) begin
         mem[tbl_req.addr] <= tbl_req.wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (tbl_req.rd_en) begin
         rd_data_ff <= mem[tbl_req.addr];
         rd_hit_ff  <= valid_ff[tbl_req.addr];
      end
   end

   // never-loaded entries read as zero
   assign rd_data = rd_hit_ff ? rd_data_ff : '0;

endmodule

>>> rtl/hcbp_checker.sv
// Port-level checks for the bit packer, bound to the top level.
`timescale 1ns / 1ps
module hcbp_checker (
   input logic              clock,
   input logic              reset,
   input logic              req_valid,
   input logic              req_stall,
   input hcbp_pkg::req_type req_data,
   input logic              rsp_valid,
   input logic              rsp_stall,
   input hcbp_pkg::rsp_type rsp_data
);
   import hcbp_pkg::*;

   logic req_take;
   assign req_take = req_valid && !req_stall;

   a_reset_quiet: assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("response valid right after reset");

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_data))
      else $error("stalled response changed");

   a_load_silent: assert property (@(posedge clock) disable iff (reset)
      req_take && req_data.command == CMD_LOAD && !rsp_valid |=> !rsp_valid)
      else $error("load request produced a response");

   a_busy_after_work: assert property (@(posedge clock) disable iff (reset)
      req_take && (req_data.command == CMD_ENCODE || req_data.command == CMD_FLUSH)
      |=> req_stall)
      else $error("encode or flush request not held off");

endmodule

bind huffman_code_bit_packer hcbp_checker u_hcbp_checker (
   .clock     (clock),
   .reset     (reset),
   .req_valid (req_valid),
   .req_stall (req_stall),
   .req_data  (req_data),
   .rsp_valid (rsp_valid),
   .rsp_stall (rsp_stall),
   .rsp_data  (rsp_data)
);

>>> verif/tb_huffman_code_bit_packer.sv
// Testbench for huffman_code_bit_packer: random and directed requests against a packing model.
`timescale 1ns / 1ps
module tb_huffman_code_bit_packer;
   import hcbp_pkg::*;

   logic    clock = 1'b0;
   logic    reset = 1'b1;
   logic    req_valid = 1'b0;
   logic    req_stall;
   req_type req_data = '0;
   logic    rsp_valid;
   logic    rsp_stall = 1'b0;
   rsp_type rsp_data;

   huffman_code_bit_packer u_dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // packing model state
   logic [WORD_W-1:0] code_tbl [SYMBOLS];
   logic [BYTE_W-1:0] pend_byte = '0;
   int unsigned       pend_bits = 0;
   rsp_type           bytes_due [$];

   req_type     req_backlog [$];
   int          n_total = 0;
   int          n_taken = 0;
   int          n_errors = 0;
   int          cyc = 0;
   logic        hold_off = 1'b0;
   logic        calm;
   rsp_type     head_byte;

   // stretches of cycles where neither side idles
   assign calm = ((cyc / 500) % 3) == 1;

   always @(posedge clock) begin
      cyc <= cyc + 1;
   end

   function automatic void shift_in(input logic b);
      if (b) begin
         pend_byte[7 - pend_bits] = 1'b1;
      end
      pend_bits++;
      if (pend_bits == 8) begin
         bytes_due.push_back('{out_byte: pend_byte, last: 1'b0});
         pend_byte = '0;
         pend_bits = 0;
      end
   endfunction

   function automatic void pack_request(input req_type r);
      logic [WORD_W-1:0] w;
      int unsigned       len;
      int                base;
      base = bytes_due.size();
      case (r.command)
         CMD_LOAD: begin
            if (int'(r.symbol) < SYMBOLS) begin
               code_tbl[r.symbol] = r.code_word;
            end
         end
         CMD_ENCODE: begin
            w = (int'(r.symbol) < SYMBOLS) ? code_tbl[r.symbol] : '0;
            if (w == '0) begin
               shift_in(1'b0);
            end else begin
               len = 0;
               for (int i = 0; i < WORD_W; i++) begin
                  if (w[i]) begin
                     len = i;
                  end
               end
               if (len > MAX_CODE_LEN) begin
                  len = MAX_CODE_LEN;
               end
               for (int i = 0; i < int'(len); i++) begin
                  shift_in(w[i]);
               end
            end
         end
         CMD_FLUSH: begin
            if (pend_bits > 0) begin
               bytes_due.push_back('{out_byte: pend_byte, last: 1'b0});
            end
            bytes_due.push_back('{out_byte: BYTE_W'(pend_bits), last: 1'b0});
            pend_byte = '0;
            pend_bits = 0;
         end
         default: begin
         end
      endcase
      if (bytes_due.size() > base) begin
         bytes_due[bytes_due.size() - 1].last = 1'b1;
      end
   endfunction

   // request driver
   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
         req_data  <= '0;
      end else begin
         if (req_valid && !req_stall) begin
            pack_request(req_data);
            n_taken <= n_taken + 1;
         end
         if (!req_valid || !req_stall) begin
            if (req_backlog.size() != 0 && (calm || $urandom_range(0, 99) >= 33)) begin
               req_data  <= req_backlog.pop_front();
               req_valid <= 1'b1;
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   // response monitor and checker
   always @(posedge clock) begin
      if (reset) begin
         rsp_stall <= 1'b0;
      end else begin
         if (rsp_valid && !rsp_stall) begin
            if (bytes_due.size() == 0) begin
               if (n_errors < 10) begin
                  $display("[%0t] unexpected byte: out_byte=%02h last=%0b",
                           $time, rsp_data.out_byte, rsp_data.last);
               end
               n_errors <= n_errors + 1;
            end else begin
               head_byte = bytes_due.pop_front();
               if (rsp_data.out_byte !== head_byte.out_byte ||
                   rsp_data.last !== head_byte.last) begin
                  if (n_errors < 10) begin
                     $display("[%0t] mismatch: want %02h/%0b, got %02h/%0b",
                              $time, head_byte.out_byte, head_byte.last,
                              rsp_data.out_byte, rsp_data.last);
                  end
                  n_errors <= n_errors + 1;
               end
            end
         end
         rsp_stall <= hold_off || (!calm && $urandom_range(0, 99) < 33);
      end
   end

   // long receiver hold-off so the packer backs up into the request side
   initial begin : hold_proc
      while (reset) @(posedge clock);
      repeat (400) @(posedge clock);
      hold_off <= 1'b1;
      repeat (250) @(posedge clock);
      hold_off <= 1'b0;
   end

   initial begin : watchdog
      #1_000_000;
      $display("tb_huffman_code_bit_packer: done, errors");
      $finish;
   end

   function automatic void queue_req(input logic [1:0] cmd, input logic [SYM_W-1:0] sym,
                                     input logic [WORD_W-1:0] word);
      req_type r;
      r.command   = cmd;
      r.symbol    = sym;
      r.code_word = word;
      req_backlog.push_back(r);
      n_total++;
   endfunction

   // mostly short codes; some empty, sentinel-only, long and fully random words
   function automatic logic [WORD_W-1:0] rand_code();
      int unsigned       len;
      logic [WORD_W-1:0] w;
      case ($urandom_range(0, 9))
         0: w = '0;
         1: w = $urandom();
         2: w = 32'h8000_0000 | $urandom();
         default: begin
            len = $urandom_range(0, 12);
            w = ($urandom() & ((32'd1 << len) - 1)) | (32'd1 << len);
         end
      endcase
      return w;
   endfunction

   initial begin : stimulus
      int          n_rand;
      int unsigned pick;
      logic [7:0]  s;
      logic [7:0]  live_syms [$];

      foreach (code_tbl[i]) begin
         code_tbl[i] = '0;
      end

      // directed: unloaded entry, flushes, sentinel only, long codes, ignored command
      queue_req(CMD_ENCODE, 8'd0, 32'h0);
      queue_req(CMD_FLUSH, 8'd0, 32'h0);
      queue_req(CMD_FLUSH, 8'd0, 32'h0);
      queue_req(CMD_LOAD, 8'd5, 32'h1);
      queue_req(CMD_ENCODE, 8'd5, 32'h0);
      queue_req(CMD_LOAD, 8'd255, 32'hFFFF_FFFF);
      queue_req(CMD_ENCODE, 8'd255, 32'h0);
      queue_req(CMD_LOAD, 8'd0, 32'h8000_0000);
      queue_req(CMD_ENCODE, 8'd0, 32'h0);
      queue_req(CMD_FLUSH, 8'd0, 32'h0);
      queue_req(CMD_LOAD, 8'd1, 32'h0000_01A5);
      queue_req(CMD_ENCODE, 8'd1, 32'h0);
      queue_req(CMD_NONE, 8'd1, 32'h1234_5678);
      queue_req(CMD_LOAD, 8'd128, 32'h2);
      queue_req(CMD_ENCODE, 8'd128, 32'h0);
      queue_req(CMD_LOAD, 8'd64, 32'h3);
      queue_req(CMD_ENCODE, 8'd64, 32'h0);
      queue_req(CMD_ENCODE, 8'd64, 32'h0);
      queue_req(CMD_FLUSH, 8'd0, 32'h0);
      queue_req(CMD_LOAD, 8'd10, 32'h0);
      queue_req(CMD_ENCODE, 8'd10, 32'h0);
      queue_req(CMD_FLUSH, 8'd255, 32'hFFFF_FFFF);
      queue_req(CMD_NONE, 8'd255, 32'hFFFF_FFFF);

      // random: build a live table, then mostly encodes of loaded symbols
      for (int k = 0; k < 16; k++) begin
         s = SYM_W'($urandom_range(0, 255));
         queue_req(CMD_LOAD, s, rand_code());
         live_syms.push_back(s);
      end
      n_rand = 16;
      while (n_rand < 225) begin
         pick = $urandom_range(0, 99);
         if (pick < 15) begin
            s = SYM_W'($urandom_range(0, 255));
            queue_req(CMD_LOAD, s, rand_code());
            live_syms.push_back(s);
            if (live_syms.size() > 24) begin
               void'(live_syms.pop_front());
            end
            n_rand++;
         end else if (pick < 25) begin
            queue_req(CMD_FLUSH, SYM_W'($urandom_range(0, 255)), $urandom());
            n_rand++;
         end else if (pick < 29) begin
            queue_req(CMD_NONE, SYM_W'($urandom_range(0, 255)), $urandom());
         end else begin
            if ($urandom_range(0, 4) != 0) begin
               s = live_syms[$urandom_range(0, live_syms.size() - 1)];
            end else begin
               s = SYM_W'($urandom_range(0, 255));
            end
            queue_req(CMD_ENCODE, s, $urandom());
            n_rand++;
         end
      end
      queue_req(CMD_FLUSH, 8'd0, 32'h0);

      repeat (10) @(posedge clock);
      reset <= 1'b0;

      while (n_taken != n_total) @(posedge clock);
      while (bytes_due.size() != 0) @(posedge clock);
      repeat (30) @(posedge clock);
      if (n_errors == 0) begin
         $display("tb_huffman_code_bit_packer: done, clean");
      end else begin
         $display("tb_huffman_code_bit_packer: done, errors");
      end
      $finish;
   end

endmodule

>>> files.f
rtl/hcbp_pkg.sv
rtl/hcbp_table.sv
rtl/huffman_code_bit_packer.sv
rtl/hcbp_checker.sv
verif/tb_huffman_code_bit_packer.sv
